@@ rtl/mqtpd_pkg.sv @@
// ----------------------------------------------------------------------------
// mqtpd_pkg
// Shared types and constants for the bank of bounded two-ended queues.
// ----------------------------------------------------------------------------
package mqtpd_pkg;

    localparam int NUM_QUEUES_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int TAG_WIDTH_DEF   = 16;

    localparam logic [3:0] LIMIT_RESET = 4'd5;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TAKE = 1'b1;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_FETCH
    } state_t;

    typedef struct packed {
        logic        command;
        logic [4:0]  queue_sel;
        logic        urgent;
        logic [15:0] payload;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] taken_payload;
        logic [3:0]  fill_after;
    } out_word_t;

endpackage

@@ rtl/multi_queue_two_priority_deque_core.sv @@
// ----------------------------------------------------------------------------
// multi_queue_two_priority_deque_core
// Bank of bounded circular two-ended queues held in on-chip memories.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid / in_stall / in_word): one command word, either an
//   add (regular at the back, urgent at the front) or a take from the front.
//   out channel (out_valid / out_stall / out_word): one status word for every
//   command: status, removed tag, and the queue's fill after the command.
//   cfg_wr_en / cfg_wr_data: one occupancy limit shared by all queues, written while idle.
// Command steps:
//   a command goes through the pointer memory read, then the update and the
//   entry memory access, then the result load. One command is in flight at a
//   time: the next command is not taken until the last one's result is loaded.
// Reset:
//   all queues come up empty (per-queue valid bits clear the pointer memory at
//   once), the limit comes up as 5. No clearing pass is needed.
// Stall:
//   the result sits in the output register while out_stall is high; the next
//   command is still accepted and waits in its last step until the output
//   register frees up.
// ----------------------------------------------------------------------------
module multi_queue_two_priority_deque_core #(
    parameter int NUM_QUEUES  = mqtpd_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqtpd_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_WIDTH   = mqtpd_pkg::TAG_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  mqtpd_pkg::in_word_t  in_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output mqtpd_pkg::out_word_t out_word,
    input  logic                 cfg_wr_en,
    input  logic [3:0]           cfg_wr_data
);
    import mqtpd_pkg::*;

    localparam int QI = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);

    typedef struct packed {
        logic [PW-1:0] head;
        logic [PW-1:0] tail;
        logic [CW-1:0] cnt;
    } qptr_t;

    qptr_t                ptr_mem [NUM_QUEUES];
    logic [TAG_WIDTH-1:0] entry_mem [NUM_QUEUES * QUEUE_DEPTH];

    state_t               state_reg, state_next;
    in_word_t             in_word_reg;
    qptr_t                ptr_rd_reg;
    logic [TAG_WIDTH-1:0] entry_rd_reg;
    logic [NUM_QUEUES-1:0] ptr_vld_reg;
    logic [3:0]           limit_reg;
    logic [1:0]           res_status_reg;
    logic [3:0]           res_fill_reg;
    logic                 res_take_reg;
    logic                 out_valid_reg;
    out_word_t            out_word_reg;

    logic                 in_fire, out_load;
    logic [QI-1:0]        in_idx, cur_idx;
    logic                 in_bank;
    qptr_t                cur_ptr, new_ptr;
    logic [8:0]           lim9, cnt9, fill9;
    logic                 add_ok, take_ok;
    logic                 ptr_wr_en, entry_wr_en, entry_rd_en;
    logic [PW-1:0]        slot;
    logic [AW-1:0]        entry_addr;
    logic [TAG_WIDTH-1:0] new_tag;
    logic [1:0]           status_c;
    logic [3:0]           fill_c;
    logic [63:0]          pl64, tk64;
    logic [15:0]          taken_c;

    function automatic logic [PW-1:0] slot_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] slot_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(QUEUE_DEPTH - 1) : p - 1'b1;
    endfunction

    assign in_idx  = QI'(9'(in_word.queue_sel));
    assign cur_idx = QI'(9'(in_word_reg.queue_sel));
    assign in_bank = 9'(in_word_reg.queue_sel) < 9'(NUM_QUEUES);
    assign pl64    = 64'(in_word_reg.payload);
    assign new_tag = pl64[TAG_WIDTH-1:0];
    assign tk64    = 64'(entry_rd_reg);
    assign taken_c = res_take_reg ? tk64[15:0] : 16'd0;

    always_comb
    begin
        cur_ptr     = ptr_vld_reg[cur_idx] ? ptr_rd_reg : '0;
        new_ptr     = cur_ptr;
        lim9        = (9'(limit_reg) > 9'(QUEUE_DEPTH)) ? 9'(QUEUE_DEPTH) : 9'(limit_reg);
        cnt9        = 9'(cur_ptr.cnt);
        add_ok      = in_bank && (in_word_reg.command == CMD_ADD) && (cnt9 < lim9);
        take_ok     = in_bank && (in_word_reg.command == CMD_TAKE) && (cnt9 != 9'd0);
        slot        = cur_ptr.tail;
        status_c    = STAT_DONE;
        if (take_ok)
        begin
            slot         = cur_ptr.head;
            new_ptr.head = slot_inc(cur_ptr.head);
            new_ptr.cnt  = cur_ptr.cnt - 1'b1;
        end
        else if (add_ok && in_word_reg.urgent)
        begin
            slot         = slot_dec(cur_ptr.head);
            new_ptr.head = slot;
            new_ptr.cnt  = cur_ptr.cnt + 1'b1;
        end
        else if (add_ok)
        begin
            new_ptr.tail = slot_inc(cur_ptr.tail);
            new_ptr.cnt  = cur_ptr.cnt + 1'b1;
        end
        else if (in_word_reg.command == CMD_TAKE)
        begin
            status_c = STAT_EMPTY;
        end
        else
        begin
            status_c = STAT_FULL;
        end
        fill9  = in_bank ? 9'(new_ptr.cnt) : 9'd0;
        fill_c = fill9[3:0];
    end

    assign entry_addr = AW'(cur_idx) * AW'(QUEUE_DEPTH) + AW'(slot);

    always_comb
    begin
        state_next  = state_reg;
        in_stall    = 1'b1;
        in_fire     = 1'b0;
        ptr_wr_en   = 1'b0;
        entry_wr_en = 1'b0;
        entry_rd_en = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    in_fire    = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                ptr_wr_en   = add_ok || take_ok;
                entry_wr_en = add_ok;
                entry_rd_en = take_ok;
                state_next  = S_FETCH;
            end
            S_FETCH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_vld_reg   <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (ptr_wr_en)
            begin
                ptr_vld_reg[cur_idx] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_word_reg <= in_word;
            ptr_rd_reg  <= ptr_mem[in_idx];
        end
        if (ptr_wr_en)
        begin
            ptr_mem[cur_idx] <= new_ptr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry_wr_en)
        begin
            entry_mem[entry_addr] <= new_tag;
        end
        if (entry_rd_en)
        begin
            entry_rd_reg <= entry_mem[entry_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOOKUP)
        begin
            res_status_reg <= status_c;
            res_fill_reg   <= fill_c;
            res_take_reg   <= take_ok;
        end
        if (out_load)
        begin
            out_word_reg.status        <= res_status_reg;
            out_word_reg.taken_payload <= taken_c;
            out_word_reg.fill_after    <= res_fill_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_rise_from_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FETCH))
        else $error("result raised outside the final step");

    a_lookup_to_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOOKUP |=> state_reg == S_FETCH)
        else $error("lookup step not followed by fetch step");

    a_one_entry_port: assert property (@(posedge clk) disable iff (!rst_n)
        entry_wr_en |-> !entry_rd_en && in_bank)
        else $error("entry memory read and written for one command");

    a_refused_no_tag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_word_reg.status != STAT_DONE)
            |-> out_word_reg.taken_payload == 16'd0)
        else $error("refused command returned a tag");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_wr_en |-> 9'(new_ptr.cnt) <= 9'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the bank of bounded two-ended queues against a cycle-free predictor.
// Each accepted command word updates the predicted slots, pointers and fill of
// the addressed queue, and the expected status word is queued. Every accepted
// status word is then compared field by field, in order. Directed commands
// cover the extremes and the limit corner cases; random phases with several
// limits, output hold-off and random idling on both sides follow.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mqtpd_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_word_t   in_word = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_word_t  out_word;
    logic       cfg_wr_en = 1'b0;
    logic [3:0] cfg_wr_data = '0;

    logic [15:0] tag_store  [NUM_QUEUES_DEF][QUEUE_DEPTH_DEF] = '{default: '0};
    logic [2:0]  front_slot [NUM_QUEUES_DEF] = '{default: '0};
    logic [2:0]  back_slot  [NUM_QUEUES_DEF] = '{default: '0};
    logic [3:0]  queue_fill [NUM_QUEUES_DEF] = '{default: '0};
    logic [3:0]  occupancy_limit = LIMIT_RESET;

    out_word_t pending_status [$];
    int        error_count = 0;
    int        gap_pct = 18;
    int        stall_pct = 18;
    int        hold_request = 0;
    int        hold_count = 0;

    multi_queue_two_priority_deque_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #1 clk = ~clk;

    initial
    begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic out_word_t apply_command(in_word_t w);
        out_word_t  r;
        logic [3:0] cap;
        logic [4:0] q;
        r = '0;
        q = w.queue_sel;
        cap = (occupancy_limit > 4'd8) ? 4'd8 : occupancy_limit;
        if (w.command == CMD_TAKE)
        begin
            if (queue_fill[q] == 4'd0)
                r.status = STAT_EMPTY;
            else
            begin
                r.taken_payload = tag_store[q][front_slot[q]];
                front_slot[q] = front_slot[q] + 3'd1;
                queue_fill[q] = queue_fill[q] - 4'd1;
                r.status = STAT_DONE;
            end
        end
        else if (queue_fill[q] >= cap)
            r.status = STAT_FULL;
        else
        begin
            if (w.urgent)
            begin
                front_slot[q] = front_slot[q] - 3'd1;
                tag_store[q][front_slot[q]] = w.payload;
            end
            else
            begin
                tag_store[q][back_slot[q]] = w.payload;
                back_slot[q] = back_slot[q] + 3'd1;
            end
            queue_fill[q] = queue_fill[q] + 4'd1;
            r.status = STAT_DONE;
        end
        r.fill_after = queue_fill[q];
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                occupancy_limit = cfg_wr_data;
            if (in_valid && !in_stall)
                pending_status.push_back(apply_command(in_word));
        end
    end

    task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
        error_count++;
        $display("%0t: %s mismatch: got %h, want %h", $realtime, field, got, want);
    endtask

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_status.size() == 0)
                report_mismatch("unexpected word", 16'(out_word), '0);
            else
            begin
                want = pending_status.pop_front();
                if (out_word.status !== want.status)
                    report_mismatch("status", 16'(out_word.status), 16'(want.status));
                if (out_word.taken_payload !== want.taken_payload)
                    report_mismatch("taken_payload", out_word.taken_payload,
                                    want.taken_payload);
                if (out_word.fill_after !== want.fill_after)
                    report_mismatch("fill_after", 16'(out_word.fill_after),
                                    16'(want.fill_after));
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_count = hold_request;
            hold_request = 0;
        end
        if (hold_count > 0)
        begin
            hold_count--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_word(in_word_t w);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_limit(logic [3:0] value);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic in_word_t make_word(logic cmd, logic [4:0] q, logic urg,
                                           logic [15:0] tag);
        in_word_t w;
        w.command   = cmd;
        w.queue_sel = q;
        w.urgent    = urg;
        w.payload   = tag;
        return w;
    endfunction

    function automatic in_word_t random_command(logic [4:0] hot_base, int hot_span,
                                                int add_pct);
        in_word_t w;
        w.command = ($urandom_range(99) < add_pct) ? CMD_ADD : CMD_TAKE;
        if ($urandom_range(99) < 80)
            w.queue_sel = 5'(hot_base + $urandom_range(hot_span - 1));
        else
            w.queue_sel = 5'($urandom);
        w.urgent  = 1'($urandom_range(1));
        w.payload = 16'($urandom);
        return w;
    endfunction

    task automatic test_directed();
        send_word(make_word(CMD_TAKE, 5'd0, 1'b0, 16'h0000));
        send_word(make_word(CMD_ADD, 5'd0, 1'b0, 16'hFFFF));
        send_word(make_word(CMD_ADD, 5'd0, 1'b1, 16'h0000));
        send_word(make_word(CMD_ADD, 5'd0, 1'b1, 16'hA5A5));
        send_word(make_word(CMD_ADD, 5'd0, 1'b0, 16'h5A5A));
        send_word(make_word(CMD_ADD, 5'd0, 1'b0, 16'h1234));
        send_word(make_word(CMD_ADD, 5'd0, 1'b0, 16'hBEEF));
        send_word(make_word(CMD_ADD, 5'd0, 1'b1, 16'hCAFE));
        repeat (6) send_word(make_word(CMD_TAKE, 5'd0, 1'b1, 16'hFFFF));
        send_word(make_word(CMD_ADD, 5'd31, 1'b1, 16'hFFFF));
        send_word(make_word(CMD_ADD, 5'd31, 1'b0, 16'h8001));
        send_word(make_word(CMD_TAKE, 5'd31, 1'b0, 16'h0000));
        send_word(make_word(CMD_TAKE, 5'd31, 1'b0, 16'h0000));
        send_word(make_word(CMD_TAKE, 5'd31, 1'b0, 16'h0000));
    endtask

    task automatic test_limit_extremes();
        set_limit(4'd0);
        send_word(make_word(CMD_ADD, 5'd7, 1'b0, 16'h1111));
        send_word(make_word(CMD_ADD, 5'd7, 1'b1, 16'h2222));
        send_word(make_word(CMD_TAKE, 5'd7, 1'b0, 16'h0000));
        set_limit(4'd15);
        for (int i = 0; i < 10; i++)
            send_word(make_word(CMD_ADD, 5'd7, 1'(i), 16'(16'h7000 + i)));
        repeat (9) send_word(make_word(CMD_TAKE, 5'd7, 1'b0, 16'h0000));
        set_limit(4'd1);
        send_word(make_word(CMD_ADD, 5'd2, 1'b1, 16'h3333));
        send_word(make_word(CMD_ADD, 5'd2, 1'b0, 16'h4444));
        send_word(make_word(CMD_TAKE, 5'd2, 1'b0, 16'h0000));
        set_limit(4'd8);
        for (int i = 0; i < 9; i++)
            send_word(make_word(CMD_ADD, 5'd9, 1'($urandom_range(1)), 16'($urandom)));
        repeat (9) send_word(make_word(CMD_TAKE, 5'd9, 1'b0, 16'h0000));
    endtask

    task automatic test_random_phases();
        logic [3:0] limit_plan [12];
        logic [4:0] hot_base;
        int         hot_span;
        int         add_pct;
        limit_plan = '{4'd1, 4'd8, 4'd3, 4'd15, 4'd0, 4'd5,
                       4'd2, 4'd7, 4'd6, 4'd4, 4'd12, 4'd8};
        foreach (limit_plan[p])
        begin
            set_limit(limit_plan[p]);
            hot_base = 5'($urandom);
            hot_span = $urandom_range(1, 4);
            add_pct  = (p % 2 == 0) ? $urandom_range(55, 80) : $urandom_range(25, 50);
            repeat (135) send_word(random_command(hot_base, hot_span, add_pct));
        end
    endtask

    task automatic test_output_holdoff();
        logic [4:0] hot_base;
        drain_results();
        hot_base = 5'($urandom);
        hold_request = 200;
        repeat (24) send_word(random_command(hot_base, 2, 60));
    endtask

    task automatic test_no_idle_stretch();
        logic [4:0] hot_base;
        gap_pct   = 0;
        stall_pct = 0;
        hot_base  = 5'($urandom);
        repeat (300) send_word(random_command(hot_base, 3, 55));
        gap_pct   = 18;
        stall_pct = 18;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_limit_extremes();
        test_random_phases();
        test_output_holdoff();
        test_no_idle_stretch();
        drain_results();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/mqtpd_pkg.sv
rtl/multi_queue_two_priority_deque_core.sv
dv/testbench.sv
